// ----- sv/assert_macros.svh -----
// Assertion macros used by the serial bit engine RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tdube_pkg.sv -----
// Types and constants of the timer-driven serial bit engine.
// No dependencies; used by the core, the output buffer and the top level.
package tdube_pkg;

    localparam int unsigned PERIOD_W = 9;
    localparam int unsigned COUNT_W  = 4;

    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET = 9'd96;
    localparam logic [COUNT_W-1:0]  DATA_BITS        = 4'd8;
    localparam logic [COUNT_W-1:0]  STOP_POS         = 4'd9;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_START_TX = 2'd1,
        CMD_START_RX = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef struct packed {
        logic       tx_line;
        logic [7:0] rx_byte;
        logic       rx_done;
        logic       tx_done;
        logic       running;
    } result_t;

endpackage

// ----- sv/tdube_core.sv -----
// State and next-state logic of the serial bit engine: bit timer, frame counter,
// shift registers and done flags. Uses tdube_pkg.
module tdube_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tdube_pkg::PERIOD_W-1:0]   cfg_data,
    input  logic                             accept,
    input  logic [1:0]                       cmd,
    input  logic [7:0]                       tx_byte,
    input  logic                             rx_line,
    output tdube_pkg::result_t               result_next,
    output tdube_pkg::result_t               result_now
);

    logic [tdube_pkg::PERIOD_W-1:0] bit_period_reg;
    logic                           tx_mode_reg, tx_mode_next;
    logic [tdube_pkg::COUNT_W-1:0]  bit_count_reg, bit_count_next;
    logic [tdube_pkg::PERIOD_W-1:0] tick_left_reg, tick_left_next;
    logic                           timer_on_reg, timer_on_next;
    logic [7:0]                     tx_shift_reg, tx_shift_next;
    logic [7:0]                     rx_shift_reg, rx_shift_next;
    logic                           line_out_reg, line_out_next;
    logic                           rx_end_reg, rx_end_next;
    logic                           tx_end_reg, tx_end_next;
    logic [tdube_pkg::COUNT_W-1:0]  count_inc;

    assign count_inc = bit_count_reg + 1'b1;

    always_comb
    begin
        tx_mode_next   = tx_mode_reg;
        bit_count_next = bit_count_reg;
        tick_left_next = tick_left_reg;
        timer_on_next  = timer_on_reg;
        tx_shift_next  = tx_shift_reg;
        rx_shift_next  = rx_shift_reg;
        line_out_next  = line_out_reg;
        rx_end_next    = rx_end_reg;
        tx_end_next    = tx_end_reg;
        unique case (tdube_pkg::cmd_t'(cmd))
            tdube_pkg::CMD_TICK:
            begin
                if (timer_on_reg)
                begin
                    if (tick_left_reg <= tdube_pkg::PERIOD_W'(1))
                    begin
                        // Timer expired: reload and move one serial bit.
                        tick_left_next = bit_period_reg;
                        if (tx_mode_reg)
                        begin
                            bit_count_next = count_inc;
                            if (count_inc <= tdube_pkg::DATA_BITS)
                            begin
                                line_out_next = tx_shift_reg[0];
                                tx_shift_next = {1'b0, tx_shift_reg[7:1]};
                            end
                            else if (count_inc == tdube_pkg::STOP_POS)
                            begin
                                line_out_next = 1'b1;
                            end
                            else
                            begin
                                bit_count_next = '0;
                                timer_on_next  = 1'b0;
                                tx_end_next    = 1'b1;
                            end
                        end
                        else
                        begin
                            if (bit_count_reg == '0)
                            begin
                                // Start bit check; a high line is a false start.
                                if (!rx_line)
                                begin
                                    rx_shift_next  = '0;
                                    bit_count_next = tdube_pkg::COUNT_W'(1);
                                end
                                else
                                begin
                                    timer_on_next = 1'b0;
                                end
                            end
                            else if (bit_count_reg <= tdube_pkg::DATA_BITS)
                            begin
                                rx_shift_next  = {rx_line, rx_shift_reg[7:1]};
                                bit_count_next = count_inc;
                            end
                            else
                            begin
                                bit_count_next = '0;
                                timer_on_next  = 1'b0;
                                if (rx_line)
                                begin
                                    rx_end_next = 1'b1;
                                end
                            end
                        end
                    end
                    else
                    begin
                        tick_left_next = tick_left_reg - 1'b1;
                    end
                end
            end
            tdube_pkg::CMD_START_TX:
            begin
                tx_shift_next  = tx_byte;
                tick_left_next = bit_period_reg;
                timer_on_next  = 1'b1;
                line_out_next  = 1'b0;
                tx_end_next    = 1'b0;
                tx_mode_next   = 1'b1;
            end
            tdube_pkg::CMD_START_RX:
            begin
                tick_left_next = bit_period_reg >> 1;
                timer_on_next  = 1'b1;
                rx_end_next    = 1'b0;
                tx_mode_next   = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= tdube_pkg::BIT_PERIOD_RESET;
            tx_mode_reg    <= 1'b0;
            bit_count_reg  <= '0;
            tick_left_reg  <= '0;
            timer_on_reg   <= 1'b0;
            tx_shift_reg   <= '0;
            rx_shift_reg   <= '0;
            line_out_reg   <= 1'b1;
            rx_end_reg     <= 1'b0;
            tx_end_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                bit_period_reg <= cfg_data;
            end
            if (accept)
            begin
                tx_mode_reg   <= tx_mode_next;
                bit_count_reg <= bit_count_next;
                tick_left_reg <= tick_left_next;
                timer_on_reg  <= timer_on_next;
                tx_shift_reg  <= tx_shift_next;
                rx_shift_reg  <= rx_shift_next;
                line_out_reg  <= line_out_next;
                rx_end_reg    <= rx_end_next;
                tx_end_reg    <= tx_end_next;
            end
        end
    end

    assign result_next.tx_line = line_out_next;
    assign result_next.rx_byte = rx_shift_next;
    assign result_next.rx_done = rx_end_next;
    assign result_next.tx_done = tx_end_next;
    assign result_next.running = timer_on_next;

    assign result_now.tx_line = line_out_reg;
    assign result_now.rx_byte = rx_shift_reg;
    assign result_now.rx_done = rx_end_reg;
    assign result_now.tx_done = tx_end_reg;
    assign result_now.running = timer_on_reg;

endmodule

// ----- sv/tdube_outbuf.sv -----
// Output register with a skid stage for the serial bit engine results.
// Uses tdube_pkg for the result word type.
module tdube_outbuf
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tdube_pkg::result_t push_data,
    output logic               full,
    output logic               out_valid,
    input  logic               out_stall,
    output tdube_pkg::result_t out_data
);

    logic               out_valid_reg;
    logic               skid_valid_reg;
    tdube_pkg::result_t out_data_reg;
    tdube_pkg::result_t skid_data_reg;
    logic               drain;

    // The output register frees up when it is empty or its word is taken.
    assign drain = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (drain)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (drain)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (push)
            begin
                out_data_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- sv/timer_driven_uart_bit_engine.sv -----
// Timer-driven 8N1 serial bit engine, top level; uses tdube_pkg, tdube_core,
// tdube_outbuf and assert_macros.svh. Each accepted word's result is registered
// into the output register, or into the skid stage while the output is stalled.
// Throughput: one word per cycle while in_stall is low; the skid stage lets one
// more word in while the output is stalled. Reset: asynchronous, active low; clears
// core state and valid flags, the core line idles high, bit_period returns to 96.
`include "assert_macros.svh"

module timer_driven_uart_bit_engine
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tdube_pkg::PERIOD_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     cmd,
    input  logic [7:0]                     tx_byte,
    input  logic                           rx_line,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           tx_line,
    output logic [7:0]                     rx_byte,
    output logic                           rx_done,
    output logic                           tx_done,
    output logic                           running
);

    logic               accept;
    logic               buf_full;
    logic               start_tx_acc;
    logic               tx_armed;
    tdube_pkg::result_t result_next;
    tdube_pkg::result_t result_now;
    tdube_pkg::result_t out_data;

    assign cfg_ready = 1'b1;
    assign in_stall  = buf_full;
    assign accept    = in_valid && !buf_full;

    tdube_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .cmd         (cmd),
        .tx_byte     (tx_byte),
        .rx_line     (rx_line),
        .result_next (result_next),
        .result_now  (result_now)
    );

    tdube_outbuf u_outbuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result_next),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign tx_line = out_data.tx_line;
    assign rx_byte = out_data.rx_byte;
    assign rx_done = out_data.rx_done;
    assign tx_done = out_data.tx_done;
    assign running = out_data.running;

    assign start_tx_acc = accept && (cmd == tdube_pkg::CMD_START_TX);
    assign tx_armed     = result_now.running && !result_now.tx_line && !result_now.tx_done;

    // The skid stage only fills behind a held output word.
    `ASSERT_IMP(a_stall_needs_output, in_stall, out_valid, "input stalled with empty output")
    // After an accepted word the output always holds a valid word on the next cycle.
    `ASSERT_NEXT(a_accept_gives_word, accept, out_valid, "accepted word produced no result")
    // Start transmit drives the start bit and arms the timer.
    `ASSERT_NEXT(a_start_tx_state, start_tx_acc, tx_armed, "start transmit not armed")

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the timer-driven 8N1 serial bit engine.
// Needs tdube_pkg and the timer_driven_uart_bit_engine RTL; every result word is
// compared field by field with a cycle-free model of the engine kept in this file, or with a fixed word for typed rows.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam tdube_pkg::result_t IDLE_RESULT     = '{1'b1, 8'h00, 1'b0, 1'b0, 1'b0};
    localparam tdube_pkg::result_t TX_START_RESULT = '{1'b0, 8'h00, 1'b0, 1'b0, 1'b1};
    localparam int                 PHASES          = 10;

    typedef struct {
        logic                           is_cfg;
        logic [tdube_pkg::PERIOD_W-1:0] period;
        tdube_pkg::cmd_t                op;
        logic [7:0]                     data;
        logic                           rxd;
        logic                           typed;
        tdube_pkg::result_t             want;
    } stim_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [tdube_pkg::PERIOD_W-1:0] cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [1:0]                     cmd = tdube_pkg::CMD_TICK;
    logic [7:0]                     tx_byte = 8'h00;
    logic                           rx_line = 1'b1;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic                           tx_line;
    logic [7:0]                     rx_byte;
    logic                           rx_done;
    logic                           tx_done;
    logic                           running;

    // Engine state as predicted from the accepted words.
    logic [tdube_pkg::PERIOD_W-1:0] eng_period = tdube_pkg::BIT_PERIOD_RESET;
    logic                           eng_tx_mode = 1'b0;
    logic [tdube_pkg::COUNT_W-1:0]  eng_bits = '0;
    logic [tdube_pkg::PERIOD_W-1:0] eng_ticks_left = '0;
    logic                           eng_timer_on = 1'b0;
    logic [7:0]                     eng_tx_shift = 8'h00;
    logic [7:0]                     eng_rx_shift = 8'h00;
    logic                           eng_line = 1'b1;
    logic                           eng_rx_done = 1'b0;
    logic                           eng_tx_done = 1'b0;

    tdube_pkg::result_t expected_results[$];
    stim_row_t          directed_rows[$];
    int                 mismatch_count = 0;
    int                 words_sent = 0;
    int                 send_gap_pct = 0;
    int                 stall_pct = 0;

    timer_driven_uart_bit_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .tx_byte   (tx_byte),
        .rx_line   (rx_line),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .tx_line   (tx_line),
        .rx_byte   (rx_byte),
        .rx_done   (rx_done),
        .tx_done   (tx_done),
        .running   (running)
    );

    always #5 clk = ~clk;

    function automatic tdube_pkg::result_t predict_word(tdube_pkg::cmd_t op, logic [7:0] data,
                                                       logic rxd);
        case (op)
            tdube_pkg::CMD_TICK:
                if (eng_timer_on)
                begin
                    if (eng_ticks_left <= 1)
                    begin
                        eng_ticks_left = eng_period;
                        if (eng_tx_mode)
                        begin
                            eng_bits = eng_bits + 1'b1;
                            if (eng_bits <= tdube_pkg::DATA_BITS)
                            begin
                                eng_line     = eng_tx_shift[0];
                                eng_tx_shift = eng_tx_shift >> 1;
                            end
                            else if (eng_bits == tdube_pkg::STOP_POS)
                                eng_line = 1'b1;
                            else
                            begin
                                eng_bits     = '0;
                                eng_timer_on = 1'b0;
                                eng_tx_done  = 1'b1;
                            end
                        end
                        else if (eng_bits == 0)
                        begin
                            // A high line at the first sample is a false start.
                            if (!rxd)
                            begin
                                eng_rx_shift = 8'h00;
                                eng_bits     = 4'd1;
                            end
                            else
                                eng_timer_on = 1'b0;
                        end
                        else if (eng_bits <= tdube_pkg::DATA_BITS)
                        begin
                            eng_rx_shift = {rxd, eng_rx_shift[7:1]};
                            eng_bits     = eng_bits + 1'b1;
                        end
                        else
                        begin
                            eng_bits     = '0;
                            eng_timer_on = 1'b0;
                            if (rxd)
                                eng_rx_done = 1'b1;
                        end
                    end
                    else
                        eng_ticks_left = eng_ticks_left - 1'b1;
                end
            tdube_pkg::CMD_START_TX:
            begin
                eng_tx_shift   = data;
                eng_ticks_left = eng_period;
                eng_timer_on   = 1'b1;
                eng_line       = 1'b0;
                eng_tx_done    = 1'b0;
                eng_tx_mode    = 1'b1;
            end
            tdube_pkg::CMD_START_RX:
            begin
                eng_ticks_left = eng_period >> 1;
                eng_timer_on   = 1'b1;
                eng_rx_done    = 1'b0;
                eng_tx_mode    = 1'b0;
            end
            default: ;
        endcase
        return '{eng_line, eng_rx_shift, eng_rx_done, eng_tx_done, eng_timer_on};
    endfunction

    task automatic send_word(tdube_pkg::cmd_t op, logic [7:0] data, logic rxd, logic typed,
                             tdube_pkg::result_t want);
        tdube_pkg::result_t guess;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        tx_byte  <= data;
        rx_line  <= rxd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        guess = predict_word(op, data, rxd);
        expected_results.push_back(typed ? want : guess);
        words_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_period(logic [tdube_pkg::PERIOD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        eng_period = value;
    endtask

    // One serial frame with a wire level that follows the bit position, or a
    // short burst of arbitrary words.
    task automatic run_frame(int stop_at);
        int         kind;
        logic [7:0] frame_byte;
        logic       good_start;
        logic       good_stop;
        logic       lvl;
        kind       = $urandom_range(0, 99);
        frame_byte = 8'($urandom_range(0, 255));
        good_start = ($urandom_range(0, 9) != 0);
        good_stop  = ($urandom_range(0, 4) != 0);
        if (kind < 8)
        begin
            repeat ($urandom_range(1, 6))
                send_word(tdube_pkg::cmd_t'($urandom_range(0, 3)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'b0, IDLE_RESULT);
            return;
        end
        send_word(kind < 54 ? tdube_pkg::CMD_START_TX : tdube_pkg::CMD_START_RX, frame_byte,
                  1'($urandom_range(0, 1)), 1'b0, IDLE_RESULT);
        while (eng_timer_on && words_sent < stop_at)
        begin
            // Restarts are rare enough that long bit periods still expire.
            if ($urandom_range(0, 10 * eng_period + 20) == 0)
                send_word($urandom_range(0, 1) ? tdube_pkg::CMD_START_TX
                                               : tdube_pkg::CMD_START_RX,
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'b0, IDLE_RESULT);
            else if ($urandom_range(0, 49) == 0)
                send_word(tdube_pkg::CMD_NONE, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'b0, IDLE_RESULT);
            else
            begin
                if (eng_bits == 0)
                    lvl = !good_start;
                else if (eng_bits <= tdube_pkg::DATA_BITS)
                    lvl = frame_byte[3'(eng_bits - 4'd1)];
                else
                    lvl = good_stop;
                if ($urandom_range(0, 15) == 0)
                    lvl = 1'($urandom_range(0, 1));
                send_word(tdube_pkg::CMD_TICK, 8'($urandom_range(0, 255)), lvl, 1'b0,
                          IDLE_RESULT);
            end
        end
        repeat ($urandom_range(0, 3))
            send_word(tdube_pkg::CMD_TICK, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'b0, IDLE_RESULT);
        if ($urandom_range(0, 29) == 0)
            drain_results();
    endtask

    function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
        out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin : result_check
        tdube_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got %0h", $time,
                         {tx_line, rx_byte, rx_done, tx_done, running});
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("tx_line", 8'(want.tx_line), 8'(tx_line));
                check_field("rx_byte", want.rx_byte, rx_byte);
                check_field("rx_done", 8'(want.rx_done), 8'(rx_done));
                check_field("tx_done", 8'(want.tx_done), 8'(tx_done));
                check_field("running", 8'(want.running), 8'(running));
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("** timer_driven_uart_bit_engine: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        logic [tdube_pkg::PERIOD_W-1:0] periods[PHASES];
        int                             budgets[PHASES];
        int                             stop_at;
        periods = '{9'd0, 9'd1, 9'd2, 9'd511, 9'd256, tdube_pkg::BIT_PERIOD_RESET,
                    9'd3, 9'd3, 9'd3, 9'd3};
        budgets = '{200, 200, 220, 260, 260, 160, 150, 150, 150, 150};
        for (int i = 6; i < PHASES; i++)
            periods[i] = 9'($urandom_range(3, 12));

        // Idle line after reset, then a one-tick-per-bit transmit of A5, a
        // receive of 3C with a good stop bit, and a false start.
        directed_rows.push_back('{1'b0, 9'd0, tdube_pkg::CMD_TICK, 8'hFF, 1'b0, 1'b1,
                                  IDLE_RESULT});
        directed_rows.push_back('{1'b0, 9'd0, tdube_pkg::CMD_NONE, 8'hFF, 1'b1, 1'b1,
                                  IDLE_RESULT});
        directed_rows.push_back('{1'b1, 9'd1, tdube_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0,
                                  IDLE_RESULT});
        directed_rows.push_back('{1'b0, 9'd0, tdube_pkg::CMD_START_TX, 8'hA5, 1'b0, 1'b1,
                                  TX_START_RESULT});
        repeat (10)
            directed_rows.push_back('{1'b0, 9'd0, tdube_pkg::CMD_TICK, 8'h00, 1'b1, 1'b0,
                                      IDLE_RESULT});
        directed_rows.push_back('{1'b0, 9'd0, tdube_pkg::CMD_START_RX, 8'h00, 1'b1, 1'b0,
                                  IDLE_RESULT});
        foreach (periods[i])
            if (i < 10)
                directed_rows.push_back('{1'b0, 9'd0, tdube_pkg::CMD_TICK, 8'h00,
                                          (i >= 3 && i <= 6) || i == 9, 1'b0, IDLE_RESULT});
        directed_rows.push_back('{1'b0, 9'd0, tdube_pkg::CMD_START_RX, 8'h00, 1'b0, 1'b0,
                                  IDLE_RESULT});
        directed_rows.push_back('{1'b0, 9'd0, tdube_pkg::CMD_TICK, 8'h00, 1'b1, 1'b0,
                                  IDLE_RESULT});

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                drain_results();
                write_period(directed_rows[i].period);
            end
            else
                send_word(directed_rows[i].op, directed_rows[i].data, directed_rows[i].rxd,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            write_period(periods[ph]);
            send_gap_pct = (ph % 4 == 1) ? 59 : (ph % 4 == 3) ? 21 : 0;
            stall_pct    = (ph % 4 == 2) ? 59 : (ph % 4 == 3) ? 21 : 0;
            stop_at      = words_sent + budgets[ph];
            while (words_sent < stop_at)
                run_frame(stop_at);
        end

        drain_results();
        repeat (20)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("** timer_driven_uart_bit_engine: PASSED **");
        else
            $display("** timer_driven_uart_bit_engine: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/tdube_pkg.sv
sv/tdube_core.sv
sv/tdube_outbuf.sv
sv/timer_driven_uart_bit_engine.sv
sim/tb.sv
